// File: hdl/fawl_pkg.sv
// Shared constants, types and register codes for the frame average unit.
// No dependencies.
`timescale 1ns / 1ps
package fawl_pkg;

  localparam int MaxPixels   = 65536;
  localparam int PaletteSize = 256;

  localparam int PosW     = $clog2(MaxPixels);
  localparam int FsW      = PosW + 1;
  localparam int PixW     = 16;
  localparam int CntW     = 16;
  localparam int FracW    = 8;
  localparam int MeanW    = PixW + FracW;
  localparam int AccW     = CntW + MeanW;
  localparam int RangeW   = 16;
  localparam int IdxW     = $clog2(PaletteSize);
  localparam int FrameW   = 17;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 17;

  typedef enum logic [CfgIdxW-1:0] {
    RegWindowLow     = 2'd0,
    RegWindowRange   = 2'd1,
    RegAccumulateAll = 2'd2,
    RegFramePixels   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PixW-1:0] shown;
    logic            frame_end;
  } map_in_t;

endpackage

// File: hdl/fawl_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module fawl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/fawl_map.sv
// Window/level mapping of a shown value to a clamped palette index.
// Pipelined ceiling divide, one quotient bit per stage; uses fawl_pkg.
`timescale 1ns / 1ps
module fawl_map import fawl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  map_in_t           in_i,
  input  logic [PixW-1:0]   window_low_i,
  input  logic [RangeW-1:0] window_range_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IdxW-1:0]   palette_index_o,
  output logic              frame_end_o
);

  localparam int AW = PixW + IdxW + 1;

  logic [RangeW-1:0] r_eff;
  logic [PixW-1:0]   d;
  logic [AW-1:0]     a_d;
  logic              big_d;

  logic              p_v_q, p_le_q, p_big_q, p_end_q;
  logic [AW-1:0]     p_a_q;

  logic [IdxW-1:0]   m_v_q;
  logic              m_le_q  [IdxW];
  logic              m_big_q [IdxW];
  logic              m_end_q [IdxW];
  logic [RangeW-1:0] m_rem_q [IdxW];
  logic [IdxW-1:0]   m_dq_q  [IdxW];
  logic [RangeW-1:0] s_rem_d [IdxW];
  logic [IdxW-1:0]   s_dq_d  [IdxW];
  logic [IdxW-1:0]   m_en;

  logic              o_v_q, o_end_q, o_en, p_en;
  logic [IdxW-1:0]   o_idx_q, o_idx_d;

  assign r_eff = (window_range_i == '0) ? RangeW'(1) : window_range_i;
  assign d     = in_i.shown - window_low_i;
  assign a_d   = {1'b0, d, {IdxW{1'b0}}} + AW'(r_eff) - AW'(1);
  assign big_d = AW'({d, {IdxW{1'b0}}}) > AW'(r_eff) * AW'(PaletteSize - 2);

  always_comb begin
    logic [RangeW-1:0] rem;
    logic [IdxW-1:0]   dq;
    logic [RangeW:0]   t;
    for (int k = 0; k < IdxW; k++) begin
      if (k == 0) begin
        rem = p_a_q[IdxW+RangeW-1:IdxW];
        dq  = p_a_q[IdxW-1:0];
      end else begin
        rem = m_rem_q[k-1];
        dq  = m_dq_q[k-1];
      end
      t = {rem, dq[IdxW-1]};
      if (t >= {1'b0, r_eff}) begin
        s_rem_d[k] = RangeW'(t - {1'b0, r_eff});
        s_dq_d[k]  = {dq[IdxW-2:0], 1'b1};
      end else begin
        s_rem_d[k] = t[RangeW-1:0];
        s_dq_d[k]  = {dq[IdxW-2:0], 1'b0};
      end
    end
  end

  assign o_en = !o_v_q || out_ready_i;
  always_comb begin
    m_en[IdxW-1] = !m_v_q[IdxW-1] || o_en;
    for (int k = IdxW - 2; k >= 0; k--) begin
      m_en[k] = !m_v_q[k] || m_en[k+1];
    end
  end
  assign p_en       = !p_v_q || m_en[0];
  assign in_ready_o = p_en;

  always_comb begin
    if (m_le_q[IdxW-1]) begin
      o_idx_d = IdxW'(1);
    end else if (m_big_q[IdxW-1]) begin
      o_idx_d = IdxW'(PaletteSize - 2);
    end else begin
      o_idx_d = m_dq_q[IdxW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
      m_v_q <= '0;
      o_v_q <= 1'b0;
    end else begin
      if (p_en) p_v_q <= in_valid_i;
      for (int k = 0; k < IdxW; k++) begin
        if (m_en[k]) m_v_q[k] <= (k == 0) ? p_v_q : m_v_q[(k == 0) ? 0 : k - 1];
      end
      if (o_en) o_v_q <= m_v_q[IdxW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_en) begin
      p_le_q  <= in_i.shown <= window_low_i;
      p_big_q <= big_d;
      p_a_q   <= a_d;
      p_end_q <= in_i.frame_end;
    end
    for (int k = 0; k < IdxW; k++) begin
      if (m_en[k]) begin
        m_rem_q[k] <= s_rem_d[k];
        m_dq_q[k]  <= s_dq_d[k];
        if (k == 0) begin
          m_le_q[k]  <= p_le_q;
          m_big_q[k] <= p_big_q;
          m_end_q[k] <= p_end_q;
        end else begin
          m_le_q[k]  <= m_le_q[(k == 0) ? 0 : k - 1];
          m_big_q[k] <= m_big_q[(k == 0) ? 0 : k - 1];
          m_end_q[k] <= m_end_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
    if (o_en) begin
      o_idx_q <= o_idx_d;
      o_end_q <= m_end_q[IdxW-1];
    end
  end

  assign out_valid_o     = o_v_q;
  assign palette_index_o = o_idx_q;
  assign frame_end_o     = o_end_q;

endmodule

// File: hdl/frame_average_window_level_map_unit.sv
// Per-pixel running frame average with window/level palette mapping.
// Top level; uses fawl_pkg, fawl_ram (mean store) and fawl_map.
//
// Pixels enter on pixel_valid_i/pixel_ready_o in raster order, one item per
// pixel; each gives one item on result_valid_o/result_ready_i: palette_index_o
// and frame_end_o (last pixel of a frame). Registers are written on
// cfg_valid_i/cfg_ready_o (cfg_ready_o is always high); the user must write
// them only while the unit is idle; the unit does not enforce it. Items go
// through one store read, one multiply, 24 divide stages (one quotient bit
// each), one prep and 8 divide stages for the palette map, and the output
// register. Throughput is one item per cycle while the frame holds more
// pixels than the 26 items between store read and write-back; smaller frames
// are interlocked on that in-flight count, since the same entry is read again
// before its update is written. Reset and any write of accumulate_all start
// a clearing pass over the 65536-entry mean store with pixel_ready_o low.
// A stalled receiver fills pipeline bubbles first, then holds pixel_ready_o
// low; no item is dropped.
`timescale 1ns / 1ps
module frame_average_window_level_map_unit import fawl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pixel_valid_i,
  output logic                pixel_ready_o,
  input  logic [PixW-1:0]     pixel_i,
  output logic                result_valid_o,
  input  logic                result_ready_i,
  output logic [IdxW-1:0]     palette_index_o,
  output logic                frame_end_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int Steps = MeanW;
  localparam int InflW = $clog2(Steps + 3);

  logic [PixW-1:0]   low_q, range_q;
  logic              acc_all_q;
  logic [FrameW-1:0] fp_q;
  logic [PosW-1:0]   pos_q, pos_d, pos_cur;
  logic [CntW-1:0]   fc_q, fc_d, n_d;
  logic [FsW-1:0]    fsize;
  logic              accept, frame_end_d, clr_q, cfg_fire, cfg_clear;
  logic [PosW-1:0]   clr_addr_q;
  logic [InflW-1:0]  infl_q;

  logic              a_v_q, a_end_q, a_en;
  logic [PosW-1:0]   a_pos_q;
  logic [CntW-1:0]   a_n_q;
  logic [PixW-1:0]   a_px_q;
  logic [MeanW-1:0]  rdata;

  logic              b_v_q, b_end_q, b_en;
  logic [PosW-1:0]   b_pos_q;
  logic [CntW-1:0]   b_n_q;
  logic [PixW-1:0]   b_px_q;
  logic [AccW-1:0]   b_acc_q;

  logic [Steps-1:0]  dv_q, d_en;
  logic [CntW-1:0]   d_rem_q [Steps];
  logic [MeanW-1:0]  d_dq_q  [Steps];
  logic [CntW-1:0]   d_n_q   [Steps];
  logic [PixW-1:0]   d_px_q  [Steps];
  logic [PosW-1:0]   d_pos_q [Steps];
  logic              d_end_q [Steps];
  logic [CntW-1:0]   s_rem_d [Steps];
  logic [MeanW-1:0]  s_dq_d  [Steps];

  logic              map_ready, wb;
  logic              ram_we;
  logic [PosW-1:0]   ram_waddr;
  logic [MeanW-1:0]  ram_wdata, q_last;
  map_in_t           map_in;

  // frame bookkeeping at the input
  always_comb begin
    if (fp_q == '0) begin
      fsize = FsW'(1);
    end else if (32'(fp_q) > MaxPixels) begin
      fsize = FsW'(MaxPixels);
    end else begin
      fsize = FsW'(fp_q);
    end
    pos_cur     = ({1'b0, pos_q} >= fsize) ? '0 : pos_q;
    fc_d        = (pos_cur == '0 && fc_q != '1) ? fc_q + 1'b1 : fc_q;
    n_d         = (fc_d == '0) ? CntW'(1) : fc_d;
    frame_end_d = {1'b0, pos_cur} == fsize - 1'b1;
    pos_d       = ({1'b0, pos_cur} + 1'b1 >= fsize) ? '0 : pos_cur + 1'b1;
  end

  assign pixel_ready_o = a_en && !clr_q && (FsW'(infl_q) < fsize);
  assign accept        = pixel_valid_i && pixel_ready_o;
  assign cfg_ready_o   = 1'b1;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;
  assign cfg_clear     = cfg_fire && (cfg_idx_e'(cfg_index_i) == RegAccumulateAll);

  // elastic pipeline enables
  always_comb begin
    d_en[Steps-1] = !dv_q[Steps-1] || map_ready;
    for (int k = Steps - 2; k >= 0; k--) begin
      d_en[k] = !dv_q[k] || d_en[k+1];
    end
  end
  assign b_en = !b_v_q || d_en[0];
  assign a_en = !a_v_q || b_en;

  // one restoring divide step per stage
  always_comb begin
    logic [CntW-1:0]  rem, n;
    logic [MeanW-1:0] dq;
    logic [CntW:0]    t;
    for (int k = 0; k < Steps; k++) begin
      if (k == 0) begin
        rem = b_acc_q[AccW-1:MeanW];
        dq  = b_acc_q[MeanW-1:0];
        n   = b_n_q;
      end else begin
        rem = d_rem_q[k-1];
        dq  = d_dq_q[k-1];
        n   = d_n_q[k-1];
      end
      t = {rem, dq[MeanW-1]};
      if (t >= {1'b0, n}) begin
        s_rem_d[k] = CntW'(t - {1'b0, n});
        s_dq_d[k]  = {dq[MeanW-2:0], 1'b1};
      end else begin
        s_rem_d[k] = t[CntW-1:0];
        s_dq_d[k]  = {dq[MeanW-2:0], 1'b0};
      end
    end
  end

  assign q_last       = d_dq_q[Steps-1];
  assign wb           = dv_q[Steps-1] && map_ready;
  assign map_in.shown = acc_all_q ? q_last[MeanW-1:FracW] : d_px_q[Steps-1];
  assign map_in.frame_end = d_end_q[Steps-1];

  assign ram_we    = clr_q || wb;
  assign ram_waddr = clr_q ? clr_addr_q : d_pos_q[Steps-1];
  assign ram_wdata = (clr_q || !acc_all_q) ? '0 : q_last;

  fawl_ram #(
    .Width(MeanW),
    .Depth(MaxPixels)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(pos_cur),
    .rdata_o(rdata)
  );

  fawl_map u_map (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (dv_q[Steps-1]),
    .in_ready_o     (map_ready),
    .in_i           (map_in),
    .window_low_i   (low_q),
    .window_range_i (range_q),
    .out_valid_o    (result_valid_o),
    .out_ready_i    (result_ready_i),
    .palette_index_o(palette_index_o),
    .frame_end_o    (frame_end_o)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q      <= '0;
      range_q    <= PixW'(300);
      acc_all_q  <= 1'b0;
      fp_q       <= FrameW'(MaxPixels);
      pos_q      <= '0;
      fc_q       <= '0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      infl_q     <= '0;
      a_v_q      <= 1'b0;
      b_v_q      <= 1'b0;
      dv_q       <= '0;
    end else begin
      if (cfg_clear) begin
        pos_q      <= '0;
        fc_q       <= '0;
        clr_q      <= 1'b1;
        clr_addr_q <= '0;
      end else begin
        if (clr_q) begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == PosW'(MaxPixels - 1)) clr_q <= 1'b0;
        end
        if (accept) begin
          pos_q <= pos_d;
          fc_q  <= fc_d;
        end
      end
      if (cfg_fire) begin
        case (cfg_idx_e'(cfg_index_i))
          RegWindowLow:     low_q     <= cfg_data_i[PixW-1:0];
          RegWindowRange:   range_q   <= cfg_data_i[PixW-1:0];
          RegAccumulateAll: acc_all_q <= cfg_data_i[0];
          RegFramePixels:   fp_q      <= cfg_data_i[FrameW-1:0];
          default: ;
        endcase
      end
      infl_q <= infl_q + InflW'(accept) - InflW'(wb);
      if (a_en) a_v_q <= accept;
      if (b_en) b_v_q <= a_v_q;
      for (int k = 0; k < Steps; k++) begin
        if (d_en[k]) dv_q[k] <= (k == 0) ? b_v_q : dv_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (a_en) begin
      a_pos_q <= pos_cur;
      a_n_q   <= n_d;
      a_px_q  <= pixel_i;
      a_end_q <= frame_end_d;
    end
    if (b_en) begin
      b_acc_q <= {{MeanW{1'b0}}, a_n_q - 1'b1} * {{CntW{1'b0}}, rdata}
               + AccW'({a_px_q, {FracW{1'b0}}});
      b_n_q   <= a_n_q;
      b_px_q  <= a_px_q;
      b_pos_q <= a_pos_q;
      b_end_q <= a_end_q;
    end
    for (int k = 0; k < Steps; k++) begin
      if (d_en[k]) begin
        d_rem_q[k] <= s_rem_d[k];
        d_dq_q[k]  <= s_dq_d[k];
        if (k == 0) begin
          d_n_q[k]   <= b_n_q;
          d_px_q[k]  <= b_px_q;
          d_pos_q[k] <= b_pos_q;
          d_end_q[k] <= b_end_q;
        end else begin
          d_n_q[k]   <= d_n_q[(k == 0) ? 0 : k - 1];
          d_px_q[k]  <= d_px_q[(k == 0) ? 0 : k - 1];
          d_pos_q[k] <= d_pos_q[(k == 0) ? 0 : k - 1];
          d_end_q[k] <= d_end_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_infl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    infl_q <= InflW'(Steps + 2))
    else $error("in-flight count exceeds pipeline depth");

  a_no_wb_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb |-> !clr_q)
    else $error("write-back during store clearing");

  a_infl_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !wb) |=> infl_q == $past(infl_q) + 1'b1)
    else $error("in-flight count missed an accepted item");

  a_empty_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (infl_q == '0) |-> (!a_v_q && !b_v_q && dv_q == '0))
    else $error("pipeline holds an item not counted");
`endif

endmodule
